/* hdl/wola_pkg.sv */
`timescale 1ns / 1ps

package wola_pkg;

    // Ring geometry and field widths
    localparam int MAX_FRAME_LEN = 1024;
    localparam int SLOT_W        = $clog2(MAX_FRAME_LEN);
    localparam int LEN_W         = 11;
    localparam int POS_W         = 20;
    localparam int FLOOR_W       = 10;
    localparam int SAMPLE_W      = 16;
    localparam int PROD_W        = 2 * SAMPLE_W;
    localparam int SQ_W          = 2 * SAMPLE_W - 1;
    localparam int WSUM_W        = 42;
    localparam int ESUM_W        = 41;
    localparam int RAM_W         = WSUM_W + ESUM_W;
    localparam int OUT_W         = 24;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 20;

    // Register reset values
    localparam logic [LEN_W-1:0]   HOP_RST   = 11'd256;
    localparam logic [LEN_W-1:0]   FRAME_RST = 11'd1024;
    localparam logic [POS_W-1:0]   SIGLEN_RST = 20'd16384;
    localparam logic [FLOOR_W-1:0] FLOOR_RST = 10'd11;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_HOP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGLEN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR  = 2'd3;

    typedef enum logic [1:0] {
        OP_SAMPLE  = 2'd0,
        OP_DRAIN   = 2'd1,
        OP_RESTART = 2'd2
    } t_opcode;

    // Emit request from the ring update to the divider
    typedef struct packed {
        logic                      valid;
        logic signed [WSUM_W-1:0]  wsum;
        logic [ESUM_W-1:0]         esum;
        logic [FLOOR_W-1:0]        floor_val;
        logic [POS_W-1:0]          pos;
        logic                      last;
    } t_div_req;

endpackage

/* hdl/windowed_overlap_add_normalize.sv */
`timescale 1ns / 1ps

// Streaming weighted overlap-add with window-energy normalization.
// Input channel (i_valid/o_ready): opcode SAMPLE carries one frame sample and
// its window coefficient; DRAIN emits the next pending position; RESTART
// starts a new signal. Output channel (o_valid/i_ready) returns at most one
// normalized sample per transaction. Config channel (i_cfg_valid/o_cfg_ready)
// writes hop, frame size, signal length and energy floor; always ready.
// A sample outside the live range of positions leaves the sequencer idle;
// one that lands on a slot but completes no position takes the ring read,
// then the write back. An emitting sample or drain holds o_ready low through
// the ring and the divider (setup, overflow check, 25 quotient bits at one
// per cycle, output load); the divider skips the quotient bits when the
// divisor is zero or the quotient overflows.
// The ring is one 1024-entry RAM holding both sums per slot. After reset and
// after each RESTART a clearing pass writes zeros over all 1024 slots, one per
// cycle, with o_ready low. A result waiting on a stalled receiver sits in the
// output register; the next transaction may still be taken, but a further
// result holds the divider until the output register frees.
module windowed_overlap_add_normalize (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [wola_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [wola_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [1:0]                           i_opcode,
    input  logic signed [wola_pkg::SAMPLE_W-1:0] i_sample_value,
    input  logic signed [wola_pkg::SAMPLE_W-1:0] i_window_coeff,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [wola_pkg::OUT_W-1:0]    o_out_value,
    output logic [wola_pkg::POS_W-1:0]           o_out_position,
    output logic                                 o_is_last,
    output logic                                 o_clipped
);

    localparam int SW = wola_pkg::SLOT_W;
    localparam int LW = wola_pkg::LEN_W;
    localparam int PW = wola_pkg::POS_W;

    typedef enum logic [2:0] {
        S_CLR  = 3'b001,
        S_IDLE = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    typedef wola_pkg::t_opcode t_opcode_l;

    t_state                           r_state;
    logic [LW-1:0]                    r_hop;
    logic [LW-1:0]                    r_frame;
    logic [PW-1:0]                    r_sig_len;
    logic [wola_pkg::FLOOR_W-1:0]     r_floor;
    logic [SW-1:0]                    r_clr;
    logic [SW-1:0]                    r_off;
    logic [PW-1:0]                    r_start;
    logic [PW-1:0]                    r_next;
    logic [SW-1:0]                    r_slot;
    logic [PW-1:0]                    r_pos;
    logic                             r_emit;
    logic signed [wola_pkg::PROD_W-1:0] r_prod;
    logic [wola_pkg::SQ_W-1:0]        r_sq;

    logic [LW-1:0]                    f_eff, h_eff;
    logic                             stale, close2, hit, emit, drain_ok, accept;
    logic [PW-1:0]                    start0, start1;
    logic [SW-1:0]                    off0;
    logic [LW-1:0]                    off1;
    logic [PW:0]                      pos0;
    t_opcode_l                        op;
    logic                             ram_we;
    logic [SW-1:0]                    ram_waddr, ram_raddr;
    logic [wola_pkg::RAM_W-1:0]       ram_wdata, ram_rdata;
    logic signed [wola_pkg::WSUM_W-1:0] wsum_new;
    logic [wola_pkg::ESUM_W-1:0]      esum_new;
    logic                             div_ready;
    wola_pkg::t_div_req               div_req;

    function automatic logic [PW-1:0] f_sat_add(input logic [PW-1:0] a,
                                                input logic [LW-1:0] b);
        logic [PW:0] s;
        s = {1'b0, a} + (PW+1)'(b);
        return s[PW] ? {PW{1'b1}} : s[PW-1:0];
    endfunction

    // Effective frame and hop
    always_comb begin
        if (r_frame == '0) begin
            f_eff = LW'(1);
        end else if (r_frame > LW'(wola_pkg::MAX_FRAME_LEN)) begin
            f_eff = LW'(wola_pkg::MAX_FRAME_LEN);
        end else begin
            f_eff = r_frame;
        end
        h_eff = (r_hop == '0) ? LW'(1) : r_hop;
        if (h_eff > f_eff) h_eff = f_eff;
    end

    // Position of the incoming sample and frame bookkeeping
    always_comb begin
        stale  = {1'b0, r_off} >= f_eff;
        start0 = stale ? f_sat_add(r_start, h_eff) : r_start;
        off0   = stale ? '0 : r_off;
        pos0   = {1'b0, start0} + (PW+1)'(off0);
        hit    = (pos0 >= {1'b0, r_next}) && (pos0 < {1'b0, r_sig_len});
        emit   = hit && ({1'b0, off0} < h_eff);
        off1   = {1'b0, off0} + LW'(1);
        close2 = off1 >= f_eff;
        start1 = close2 ? f_sat_add(start0, h_eff) : start0;
        drain_ok = r_next < r_sig_len;
    end

    assign op      = t_opcode_l'(i_opcode);
    assign o_ready = (r_state == S_IDLE) && div_ready;
    assign accept  = i_valid && o_ready;

    // Sequencer and ring pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_off   <= '0;
            r_start <= '0;
            r_next  <= '0;
        end else begin
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == {SW{1'b1}}) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (accept) begin
                        case (op)
                            wola_pkg::OP_SAMPLE: begin
                                r_off   <= close2 ? '0 : off1[SW-1:0];
                                r_start <= start1;
                                if (hit) begin
                                    r_state <= S_UPD;
                                    if (emit) r_next <= f_sat_add(pos0[PW-1:0], LW'(1));
                                end
                            end
                            wola_pkg::OP_DRAIN: begin
                                if (drain_ok) begin
                                    r_state <= S_UPD;
                                    r_next  <= f_sat_add(r_next, LW'(1));
                                end
                            end
                            wola_pkg::OP_RESTART: begin
                                r_state <= S_CLR;
                                r_clr   <= '0;
                                r_off   <= '0;
                                r_start <= '0;
                                r_next  <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_UPD: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Item registers: slot, position and products
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (op == wola_pkg::OP_DRAIN) begin
                r_slot <= r_next[SW-1:0];
                r_pos  <= r_next;
                r_emit <= 1'b1;
                r_prod <= '0;
                r_sq   <= '0;
            end else begin
                r_slot <= pos0[SW-1:0];
                r_pos  <= pos0[PW-1:0];
                r_emit <= emit;
                r_prod <= i_sample_value * i_window_coeff;
                r_sq   <= wola_pkg::SQ_W'(i_window_coeff * i_window_coeff);
            end
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hop     <= wola_pkg::HOP_RST;
            r_frame   <= wola_pkg::FRAME_RST;
            r_sig_len <= wola_pkg::SIGLEN_RST;
            r_floor   <= wola_pkg::FLOOR_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                wola_pkg::CFG_HOP:    r_hop     <= i_cfg_data[LW-1:0];
                wola_pkg::CFG_FRAME:  r_frame   <= i_cfg_data[LW-1:0];
                wola_pkg::CFG_SIGLEN: r_sig_len <= i_cfg_data[PW-1:0];
                wola_pkg::CFG_FLOOR:  r_floor   <= i_cfg_data[wola_pkg::FLOOR_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Read-modify-write of the ring slot
    always_comb begin
        wsum_new = $signed(ram_rdata[wola_pkg::RAM_W-1:wola_pkg::ESUM_W])
                 + wola_pkg::WSUM_W'(r_prod);
        esum_new = ram_rdata[wola_pkg::ESUM_W-1:0] + wola_pkg::ESUM_W'(r_sq);
        ram_raddr = (op == wola_pkg::OP_DRAIN) ? r_next[SW-1:0] : pos0[SW-1:0];
        if (r_state == S_CLR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = '0;
        end else begin
            ram_we    = (r_state == S_UPD);
            ram_waddr = r_slot;
            ram_wdata = r_emit ? '0 : {wsum_new, esum_new};
        end
        div_req.valid     = (r_state == S_UPD) && r_emit;
        div_req.wsum      = wsum_new;
        div_req.esum      = esum_new;
        div_req.floor_val = r_floor;
        div_req.pos       = r_pos;
        div_req.last      = (r_sig_len != '0) && (r_pos == r_sig_len - 1'b1);
    end

    wola_ram #(
        .WIDTH (wola_pkg::RAM_W),
        .DEPTH (wola_pkg::MAX_FRAME_LEN)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    wola_div u_div (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (div_req),
        .o_req_ready    (div_ready),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_value    (o_out_value),
        .o_out_position (o_out_position),
        .o_is_last      (o_is_last),
        .o_clipped      (o_clipped)
    );

endmodule

/* hdl/wola_ram.sv */
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle
module wola_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/wola_div.sv */
`timescale 1ns / 1ps

// Normalizing divider: rounds wsum / max(esum, floor) to Q8.15 with saturation.
// Restoring division, one quotient bit per cycle, owns the output register.
module wola_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  wola_pkg::t_div_req                  i_req,
    output logic                                o_req_ready,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [wola_pkg::OUT_W-1:0]   o_out_value,
    output logic [wola_pkg::POS_W-1:0]          o_out_position,
    output logic                                o_is_last,
    output logic                                o_clipped
);

    localparam int QBITS = wola_pkg::OUT_W + 1;
    localparam int NUM_W = wola_pkg::WSUM_W + 17;
    localparam int DEN_W = wola_pkg::ESUM_W + 1;
    localparam int DSH_W = DEN_W + QBITS;
    localparam int CNT_W = $clog2(QBITS + 1);
    localparam logic [QBITS-1:0] POS_LIM = QBITS'((1 << (wola_pkg::OUT_W - 1)) - 1);
    localparam logic [QBITS-1:0] NEG_LIM = QBITS'(1 << (wola_pkg::OUT_W - 1));

    typedef enum logic [3:0] {
        D_IDLE = 4'b0001,
        D_PREP = 4'b0010,
        D_RUN  = 4'b0100,
        D_HOLD = 4'b1000
    } t_dstate;

    t_dstate                          r_state, n_state;
    wola_pkg::t_div_req               r_req;
    logic [NUM_W-1:0]                 r_rem;
    logic [DSH_W-1:0]                 r_dsh;
    logic [QBITS-1:0]                 r_q;
    logic [CNT_W-1:0]                 r_cnt;
    logic                             r_neg;
    logic                             r_sat;
    logic                             r_out_valid;
    logic signed [wola_pkg::OUT_W-1:0] r_out_value;
    logic [wola_pkg::POS_W-1:0]       r_out_pos;
    logic                             r_out_last;
    logic                             r_out_clip;

    logic [wola_pkg::WSUM_W-1:0] mag;
    logic [wola_pkg::ESUM_W-1:0] den;
    logic                        ge;
    logic                        clip;
    logic [QBITS-1:0]            qmag;
    logic                        out_free;

    // Magnitude and floored divisor
    always_comb begin
        mag = r_req.wsum[wola_pkg::WSUM_W-1] ? wola_pkg::WSUM_W'(-r_req.wsum)
                                             : wola_pkg::WSUM_W'(r_req.wsum);
        den = (r_req.esum < wola_pkg::ESUM_W'(r_req.floor_val))
            ? wola_pkg::ESUM_W'(r_req.floor_val) : r_req.esum;
    end

    assign ge = {{(DSH_W-NUM_W){1'b0}}, r_rem} >= r_dsh;

    // Final saturation
    always_comb begin
        if (r_neg) begin
            clip = r_sat || (r_q > NEG_LIM);
            qmag = clip ? NEG_LIM : r_q;
        end else begin
            clip = r_sat || (r_q > POS_LIM);
            qmag = clip ? POS_LIM : r_q;
        end
    end

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            D_IDLE: if (i_req.valid) n_state = D_PREP;
            D_PREP: n_state = (den == '0) ? D_HOLD : D_RUN;
            D_RUN: begin
                if ((r_cnt == CNT_W'(QBITS) && ge) || r_cnt == '0) begin
                    n_state = D_HOLD;
                end
            end
            D_HOLD: if (out_free) n_state = D_IDLE;
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= D_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == D_HOLD && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            D_IDLE: begin
                if (i_req.valid) begin
                    r_req <= i_req;
                end
            end
            D_PREP: begin
                r_neg <= r_req.wsum[wola_pkg::WSUM_W-1];
                r_sat <= 1'b0;
                r_q   <= '0;
                r_cnt <= CNT_W'(QBITS);
                r_rem <= ({{(NUM_W-wola_pkg::WSUM_W){1'b0}}, mag} << 16)
                       + NUM_W'(den);
                r_dsh <= DSH_W'({den, 1'b0}) << QBITS;
            end
            D_RUN: begin
                if (r_cnt == CNT_W'(QBITS)) begin
                    r_sat <= ge;
                end else begin
                    if (ge) begin
                        r_rem <= r_rem - NUM_W'(r_dsh);
                    end
                    r_q <= {r_q[QBITS-2:0], ge};
                end
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - 1'b1;
            end
            D_HOLD: begin
                if (out_free) begin
                    r_out_value <= r_neg ? wola_pkg::OUT_W'(-qmag)
                                         : wola_pkg::OUT_W'(qmag);
                    r_out_pos   <= r_req.pos;
                    r_out_last  <= r_req.last;
                    r_out_clip  <= clip;
                end
            end
            default: ;
        endcase
    end

    assign o_req_ready    = (r_state == D_IDLE);
    assign o_valid        = r_out_valid;
    assign o_out_value    = r_out_value;
    assign o_out_position = r_out_pos;
    assign o_is_last      = r_out_last;
    assign o_clipped      = r_out_clip;

endmodule
